// ===== rtl/fdc_pkg.sv =====
`timescale 1ns / 1ps

package fdc_pkg;

    // Disk geometry and FIFO size
    localparam int SECTORS_PER_TRACK = 18;
    localparam int HEADS_PER_CYL     = 2;
    localparam int FIFO_DEPTH        = 16;
    localparam int FIFO_IDX_W        = $clog2(FIFO_DEPTH);
    localparam int FIFO_POS_W        = 5;
    localparam int FIFO_POS_MAX      = 2 ** FIFO_POS_W - 1;
    localparam int LBA_W             = 14;
    localparam int SECTORS_PER_CYL   = SECTORS_PER_TRACK * HEADS_PER_CYL;

    // Reciprocal used for the division by sectors per cylinder
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP       = (2 ** RECIP_SHIFT + SECTORS_PER_CYL - 1) / SECTORS_PER_CYL;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int PROD_W      = LBA_W + RECIP_W;

    // Port offsets
    localparam logic [2:0] PORT_DOR  = 3'd2;
    localparam logic [2:0] PORT_MSR  = 3'd4;
    localparam logic [2:0] PORT_FIFO = 3'd5;
    localparam logic [2:0] PORT_CCR  = 3'd7;

    // Command codes, low nibble of the first byte
    localparam logic [3:0] OP_SPECIFY   = 4'h3;
    localparam logic [3:0] OP_READ_DATA = 4'h6;
    localparam logic [3:0] OP_RECAL     = 4'h7;
    localparam logic [3:0] OP_SENSE_INT = 4'h8;
    localparam logic [3:0] OP_READ_ID   = 4'hA;
    localparam logic [3:0] OP_SEEK      = 4'hF;

    // Main status bits
    localparam logic [7:0] MSR_RDY  = 8'h80;
    localparam logic [7:0] MSR_DIO  = 8'h40;
    localparam logic [7:0] MSR_NDMA = 8'h20;
    localparam logic [7:0] MSR_BUSY = 8'h10;

    localparam int DOR_RST_BIT = 2;
    localparam int MT_BIT      = 7;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_PORT  = 2'd1;
    localparam logic [1:0] ERR_CMD   = 2'd2;
    localparam logic [1:0] ERR_NO_MT = 2'd3;

    typedef struct packed {
        logic       action;
        logic [2:0] port_offset;
        logic [7:0] write_data;
        logic [7:0] sectors_done;
    } fdc_in_t;

    typedef struct packed {
        logic [7:0]       read_data;
        logic             irq_level;
        logic             irq_pulse;
        logic             dma_request;
        logic [LBA_W-1:0] dma_lba;
        logic [7:0]       dma_count;
        logic [1:0]       error_code;
    } fdc_out_t;

    typedef struct packed {
        logic [7:0] cylinder;
        logic [7:0] head;
        logic [7:0] sector;
    } fdc_chs_t;

    // Number of bytes a command needs, zero for an unknown command
    function automatic logic [3:0] cmd_len(input logic [3:0] op);
        logic [3:0] len;
        case (op)
            OP_SPECIFY:   len = 4'd2;
            OP_READ_DATA: len = 4'd9;
            OP_RECAL:     len = 4'd2;
            OP_SENSE_INT: len = 4'd1;
            OP_READ_ID:   len = 4'd2;
            OP_SEEK:      len = 4'd3;
            default:      len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/fdc_chs_conv.sv =====
`timescale 1ns / 1ps

module fdc_chs_conv
    import fdc_pkg::*;
(
    input  logic [LBA_W-1:0] lba,
    output fdc_chs_t         chs
);

    logic [PROD_W-1:0] prod;
    logic [LBA_W-1:0]  quot;
    logic [LBA_W-1:0]  quot_scaled;
    logic [LBA_W-1:0]  rem;
    logic              upper_head;
    logic [LBA_W-1:0]  sec_index;

    // The reciprocal is rounded up; for a 14-bit dividend the error stays
    // well under one part in the divisor, so the quotient is exact.
    assign prod        = PROD_W'(lba) * PROD_W'(RECIP);
    assign quot        = LBA_W'(prod[PROD_W-1:RECIP_SHIFT]);
    assign quot_scaled = quot * LBA_W'(SECTORS_PER_CYL);
    assign rem         = lba - quot_scaled;

    // The remainder is below two tracks, so one compare gives the head.
    assign upper_head = (rem >= LBA_W'(SECTORS_PER_TRACK));
    assign sec_index  = upper_head ? rem - LBA_W'(SECTORS_PER_TRACK) : rem;

    assign chs.cylinder = quot[7:0];
    assign chs.head     = {7'd0, upper_head};
    assign chs.sector   = sec_index[7:0] + 8'd1;

endmodule

// ===== rtl/floppy_controller_command_fifo.sv =====
`timescale 1ns / 1ps

// A bus word is held in the input register, and its result word in the output register.
// Throughput: one bus word per cycle while results are taken; a result word that
// is not taken stops intake once the input register is also full.
// Reset (rst_n low, asynchronous) empties the pipeline, sets the main status
// to ready, clears the FIFO pointers, interrupt and position (sector 1).
// FIFO contents are not reset.
module floppy_controller_command_fifo
    import fdc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     bus_valid,
    output logic     bus_ready,
    input  fdc_in_t  bus_item,
    output logic     res_valid,
    input  logic     res_ready,
    output fdc_out_t res_item
);

    fdc_in_t               item_reg;
    logic                  item_valid_reg;
    fdc_out_t              res_reg;
    logic                  res_valid_reg;
    logic                  advance;

    logic [7:0]            msr_reg;
    logic [7:0]            msr_next;
    logic [7:0]            fifo_reg [FIFO_DEPTH];
    logic [7:0]            fifo_next [FIFO_DEPTH];
    logic [FIFO_POS_W-1:0] pos_reg;
    logic [FIFO_POS_W-1:0] pos_next;
    logic [2:0]            rlen_reg;
    logic [2:0]            rlen_next;
    logic [7:0]            cyl_reg;
    logic [7:0]            cyl_next;
    logic [7:0]            head_reg;
    logic [7:0]            head_next;
    logic [7:0]            sec_reg;
    logic [7:0]            sec_next;
    logic                  irq_reg;
    logic                  irq_next;
    fdc_out_t              res_next;

    logic [LBA_W-1:0]      lba_reg;
    logic [LBA_W-1:0]      lba_next;
    logic [19:0]           lba_wide;
    logic [LBA_W-1:0]      end_lba;
    fdc_chs_t              end_chs;

    logic                  pos_in_range;
    logic [FIFO_POS_W-1:0] pos_step;
    logic [7:0]            first_byte;
    logic [3:0]            op;
    logic [3:0]            need;

    assign advance   = item_valid_reg && (!res_valid_reg || res_ready);
    assign bus_ready = !item_valid_reg || advance;
    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

    // Start sector of a read-data command, taken from the stored C, H, S
    // bytes. Those bytes are always written several words before the
    // command completes, so a registered copy is up to date when needed.
    assign lba_wide = ({12'd0, fifo_reg[2]} * 20'(HEADS_PER_CYL) + {12'd0, fifo_reg[3]})
                      * 20'(SECTORS_PER_TRACK) + {12'd0, fifo_reg[4]} - 20'd1;
    assign lba_next = lba_wide[LBA_W-1:0];
    assign end_lba  = lba_reg + LBA_W'(item_reg.sectors_done);

    fdc_chs_conv u_chs_conv (
        .lba (end_lba),
        .chs (end_chs)
    );

    assign pos_in_range = (pos_reg < FIFO_POS_W'(FIFO_DEPTH));
    assign first_byte   = (pos_reg == '0) ? item_reg.write_data : fifo_reg[0];
    assign op           = first_byte[3:0];
    assign need         = cmd_len(op);

    always_comb
    begin
        msr_next  = msr_reg;
        fifo_next = fifo_reg;
        pos_next  = pos_reg;
        rlen_next = rlen_reg;
        cyl_next  = cyl_reg;
        head_next = head_reg;
        sec_next  = sec_reg;
        irq_next  = irq_reg;
        res_next  = '0;
        pos_step  = pos_reg;

        if (!item_reg.action) begin
            if (item_reg.port_offset == PORT_MSR) begin
                res_next.read_data = msr_reg;
            end
            else if (item_reg.port_offset == PORT_FIFO) begin
                res_next.read_data = pos_in_range ? fifo_reg[pos_reg[FIFO_IDX_W-1:0]] : 8'd0;
                if (pos_reg != FIFO_POS_W'(FIFO_POS_MAX)) begin
                    pos_step = pos_reg + FIFO_POS_W'(1);
                end
                pos_next = pos_step;
                if (pos_step >= FIFO_POS_W'(rlen_reg)) begin
                    pos_next = '0;
                    msr_next = MSR_RDY | MSR_NDMA;
                    irq_next = 1'b0;
                end
            end
            else begin
                res_next.error_code = ERR_PORT;
            end
        end
        else begin
            case (item_reg.port_offset)
                PORT_DOR:
                begin
                    if (item_reg.write_data[DOR_RST_BIT]) begin
                        msr_next           = MSR_RDY;
                        pos_next           = '0;
                        rlen_next          = '0;
                        cyl_next           = 8'd0;
                        head_next          = 8'd0;
                        sec_next           = 8'd1;
                        irq_next           = 1'b1;
                        res_next.irq_pulse = 1'b1;
                    end
                end
                PORT_CCR:
                begin
                    // Data rate select is accepted but not stored.
                end
                PORT_FIFO:
                begin
                    if (need == 4'd0) begin
                        res_next.error_code = ERR_CMD;
                    end
                    else begin
                        msr_next = msr_reg | MSR_BUSY;
                        if (pos_in_range) begin
                            fifo_next[pos_reg[FIFO_IDX_W-1:0]] = item_reg.write_data;
                            pos_step = pos_reg + FIFO_POS_W'(1);
                        end
                        pos_next = pos_step;
                        if (pos_step >= FIFO_POS_W'(need)) begin
                            case (op)
                                OP_SPECIFY:
                                begin
                                    pos_next  = '0;
                                    rlen_next = '0;
                                end
                                OP_READ_DATA:
                                begin
                                    if (!fifo_next[0][MT_BIT]) begin
                                        res_next.error_code = ERR_NO_MT;
                                        pos_next            = '0;
                                        rlen_next           = '0;
                                        msr_next            = MSR_RDY;
                                    end
                                    else begin
                                        res_next.dma_request = 1'b1;
                                        res_next.dma_lba     = lba_reg;
                                        res_next.dma_count   = fifo_next[6];
                                        cyl_next             = end_chs.cylinder;
                                        head_next            = end_chs.head;
                                        sec_next             = end_chs.sector;
                                        fifo_next[0]         = 8'd0;
                                        fifo_next[1]         = 8'd0;
                                        fifo_next[2]         = 8'd0;
                                        fifo_next[3]         = end_chs.cylinder;
                                        fifo_next[4]         = end_chs.head;
                                        fifo_next[5]         = end_chs.sector;
                                        fifo_next[6]         = 8'd2;
                                        rlen_next            = 3'd7;
                                        pos_next             = '0;
                                        msr_next             = MSR_RDY | MSR_DIO;
                                        irq_next             = 1'b1;
                                    end
                                end
                                OP_RECAL:
                                begin
                                    cyl_next           = 8'd0;
                                    head_next          = 8'd0;
                                    sec_next           = 8'd1;
                                    msr_next           = MSR_RDY;
                                    pos_next           = '0;
                                    irq_next           = 1'b1;
                                    res_next.irq_pulse = 1'b1;
                                end
                                OP_SENSE_INT:
                                begin
                                    msr_next     = MSR_RDY | MSR_DIO;
                                    rlen_next    = 3'd2;
                                    pos_next     = '0;
                                    fifo_next[0] = 8'd0;
                                    fifo_next[1] = 8'd0;
                                    irq_next     = 1'b0;
                                end
                                OP_READ_ID:
                                begin
                                    fifo_next[0] = 8'd0;
                                    fifo_next[1] = 8'd0;
                                    fifo_next[2] = 8'd0;
                                    fifo_next[3] = cyl_reg;
                                    fifo_next[4] = head_reg;
                                    fifo_next[5] = sec_reg;
                                    fifo_next[6] = 8'd2;
                                    rlen_next    = 3'd7;
                                    pos_next     = '0;
                                    msr_next     = MSR_RDY | MSR_DIO;
                                    irq_next     = 1'b1;
                                end
                                default:
                                begin
                                    // Seek: the head number sits above the drive select bits.
                                    head_next = {2'd0, fifo_next[1][7:2]};
                                    cyl_next  = fifo_next[2];
                                    pos_next  = '0;
                                    rlen_next = '0;
                                    msr_next  = MSR_RDY | MSR_NDMA;
                                    irq_next  = 1'b1;
                                end
                            endcase
                        end
                    end
                end
                default:
                begin
                    res_next.error_code = ERR_PORT;
                end
            endcase
        end

        res_next.irq_level = irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            msr_reg        <= MSR_RDY;
            pos_reg        <= '0;
            rlen_reg       <= '0;
            cyl_reg        <= 8'd0;
            head_reg       <= 8'd0;
            sec_reg        <= 8'd1;
            irq_reg        <= 1'b0;
        end
        else begin
            if (bus_ready) begin
                item_valid_reg <= bus_valid;
            end
            if (advance) begin
                res_valid_reg <= 1'b1;
                msr_reg       <= msr_next;
                pos_reg       <= pos_next;
                rlen_reg      <= rlen_next;
                cyl_reg       <= cyl_next;
                head_reg      <= head_next;
                sec_reg       <= sec_next;
                irq_reg       <= irq_next;
            end
            else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (bus_ready && bus_valid) begin
            item_reg <= bus_item;
        end
        if (advance) begin
            res_reg   <= res_next;
            fifo_reg  <= fifo_next;
        end
        lba_reg <= lba_next;
    end

endmodule

// ===== tb/floppy_controller_command_fifo_tb.sv =====
`timescale 1ns / 1ps

module floppy_controller_command_fifo_tb;
    import fdc_pkg::*;

    localparam logic       ACT_READ       = 1'b0;
    localparam logic       ACT_WRITE      = 1'b1;
    localparam logic [2:0] PORT_SPARE_LO  = 3'd0;
    localparam logic [2:0] PORT_SPARE_HI  = 3'd6;
    localparam int unsigned LBA_MASK      = (1 << LBA_W) - 1;
    localparam int         QUIET_LIMIT    = 2000;
    localparam int         RX_HOLD_CYCLES = 300;
    localparam int         DRAIN_CYCLES   = 10;
    localparam int         PHASE_WORDS    = 230;

    typedef struct {
        fdc_in_t  word;
        bit       known;
        fdc_out_t want;
    } plan_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     bus_valid = 1'b0;
    logic     bus_ready;
    fdc_in_t  bus_item = '0;
    logic     res_valid;
    logic     res_ready = 1'b0;
    fdc_out_t res_item;

    // Mirror of the controller state.
    logic [7:0]            status_reg;
    logic [7:0]            cmd_bytes [FIFO_DEPTH];
    logic [FIFO_DEPTH-1:0] cmd_filled;
    logic [4:0]            cmd_ptr;
    logic [2:0]            result_cnt;
    logic [7:0]            cyl_now;
    logic [7:0]            head_now;
    logic [7:0]            sector_now;
    logic                  irq_now;

    fdc_out_t  result_q [$];
    plan_row_t plan [$];
    int        fail_count = 0;
    int        sent_words = 0;
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;
    int        hold_asked = 0;
    int        hold_served = 0;
    int        quiet_cycles = 0;

    floppy_controller_command_fifo u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bus_valid (bus_valid),
        .bus_ready (bus_ready),
        .bus_item  (bus_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic int bytes_for(input logic [3:0] op);
        case (op)
            OP_SPECIFY:   return 2;
            OP_READ_DATA: return 9;
            OP_RECAL:     return 2;
            OP_SENSE_INT: return 1;
            OP_READ_ID:   return 2;
            OP_SEEK:      return 3;
            default:      return 0;
        endcase
    endfunction

    function automatic void put_byte(input int idx, input logic [7:0] val);
        cmd_bytes[idx]  = val;
        cmd_filled[idx] = 1'b1;
    endfunction

    function automatic void home_state();
        status_reg = MSR_RDY;
        cmd_ptr    = '0;
        result_cnt = '0;
        cyl_now    = 8'd0;
        head_now   = 8'd0;
        sector_now = 8'd1;
    endfunction

    function automatic void load_id_result();
        put_byte(0, 8'h00);
        put_byte(1, 8'h00);
        put_byte(2, 8'h00);
        put_byte(3, cyl_now);
        put_byte(4, head_now);
        put_byte(5, sector_now);
        put_byte(6, 8'h02);
        result_cnt = 3'd7;
        cmd_ptr    = '0;
        status_reg = MSR_RDY | MSR_DIO;
    endfunction

    function automatic void model_reset();
        home_state();
        irq_now    = 1'b0;
        cmd_filled = '0;
        for (int i = 0; i < FIFO_DEPTH; i++)
            cmd_bytes[i] = 8'h00;
    endfunction

    // Applies one bus word to the mirrored state and returns the result word.
    function automatic fdc_out_t bus_access_result(input fdc_in_t w);
        fdc_out_t    r;
        logic [7:0]  first;
        logic [3:0]  op;
        int          need;
        int unsigned cyl_in, head_in, sec_in, lba, fin, rem;
        r = '0;
        if (w.action == ACT_READ) begin
            if (w.port_offset == PORT_MSR) begin
                r.read_data = status_reg;
            end else if (w.port_offset == PORT_FIFO) begin
                r.read_data = (cmd_ptr < FIFO_DEPTH) ?
                              cmd_bytes[cmd_ptr[FIFO_IDX_W-1:0]] : 8'h00;
                if (cmd_ptr < FIFO_POS_MAX)
                    cmd_ptr = cmd_ptr + 5'd1;
                if (cmd_ptr >= result_cnt) begin
                    cmd_ptr    = '0;
                    status_reg = MSR_RDY | MSR_NDMA;
                    irq_now    = 1'b0;
                end
            end else begin
                r.error_code = ERR_PORT;
            end
        end else if (w.port_offset == PORT_DOR) begin
            if (w.write_data[DOR_RST_BIT]) begin
                home_state();
                irq_now     = 1'b1;
                r.irq_pulse = 1'b1;
            end
        end else if (w.port_offset == PORT_CCR) begin
            r = '0;
        end else if (w.port_offset == PORT_FIFO) begin
            // Once a command has started, its opcode comes from the first stored byte.
            first = (cmd_ptr == 0) ? w.write_data : cmd_bytes[0];
            op    = first[3:0];
            need  = bytes_for(op);
            if (need == 0) begin
                r.error_code = ERR_CMD;
            end else begin
                status_reg = status_reg | MSR_BUSY;
                if (cmd_ptr < FIFO_DEPTH) begin
                    put_byte(cmd_ptr, w.write_data);
                    cmd_ptr = cmd_ptr + 5'd1;
                end
                if (cmd_ptr >= need) begin
                    case (op)
                        OP_SPECIFY: begin
                            cmd_ptr    = '0;
                            result_cnt = '0;
                        end
                        OP_READ_DATA: begin
                            if (!cmd_bytes[0][MT_BIT]) begin
                                r.error_code = ERR_NO_MT;
                                cmd_ptr      = '0;
                                result_cnt   = '0;
                                status_reg   = MSR_RDY;
                            end else begin
                                cyl_in  = cmd_bytes[2];
                                head_in = cmd_bytes[3];
                                sec_in  = cmd_bytes[4];
                                lba = ((cyl_in * HEADS_PER_CYL + head_in) * SECTORS_PER_TRACK
                                       + sec_in - 1) & LBA_MASK;
                                fin = (lba + w.sectors_done) & LBA_MASK;
                                rem = fin % SECTORS_PER_CYL;
                                r.dma_request = 1'b1;
                                r.dma_lba     = lba[LBA_W-1:0];
                                r.dma_count   = cmd_bytes[6];
                                cyl_now    = 8'(fin / SECTORS_PER_CYL);
                                head_now   = 8'(rem / SECTORS_PER_TRACK);
                                sector_now = 8'(rem % SECTORS_PER_TRACK + 1);
                                load_id_result();
                                irq_now = 1'b1;
                            end
                        end
                        OP_RECAL: begin
                            cyl_now     = 8'd0;
                            head_now    = 8'd0;
                            sector_now  = 8'd1;
                            status_reg  = MSR_RDY;
                            cmd_ptr     = '0;
                            irq_now     = 1'b1;
                            r.irq_pulse = 1'b1;
                        end
                        OP_SENSE_INT: begin
                            status_reg = MSR_RDY | MSR_DIO;
                            result_cnt = 3'd2;
                            cmd_ptr    = '0;
                            put_byte(0, 8'h00);
                            put_byte(1, 8'h00);
                            irq_now = 1'b0;
                        end
                        OP_READ_ID: begin
                            load_id_result();
                            irq_now = 1'b1;
                        end
                        default: begin
                            head_now   = cmd_bytes[1] >> 2;
                            cyl_now    = cmd_bytes[2];
                            cmd_ptr    = '0;
                            result_cnt = '0;
                            status_reg = MSR_RDY | MSR_NDMA;
                            irq_now    = 1'b1;
                        end
                    endcase
                end
            end
        end else begin
            r.error_code = ERR_PORT;
        end
        r.irq_level = irq_now;
        return r;
    endfunction

    function automatic fdc_out_t want_of(input logic [7:0] rd, input logic irq,
                                         input logic pulse, input logic [1:0] err);
        fdc_out_t r;
        r = '0;
        r.read_data  = rd;
        r.irq_level  = irq;
        r.irq_pulse  = pulse;
        r.error_code = err;
        return r;
    endfunction

    function automatic fdc_in_t make_word(input logic act, input logic [2:0] port,
                                          input logic [7:0] data);
        fdc_in_t w;
        w.action       = act;
        w.port_offset  = port;
        w.write_data   = data;
        w.sectors_done = 8'($urandom_range(255));
        return w;
    endfunction

    task automatic add_row(input logic act, input logic [2:0] port, input logic [7:0] data,
                           input logic [7:0] done, input bit known, input fdc_out_t want);
        plan_row_t row;
        row.word.action       = act;
        row.word.port_offset  = port;
        row.word.write_data   = data;
        row.word.sectors_done = done;
        row.known             = known;
        row.want              = want;
        plan.push_back(row);
    endtask

    task automatic send_word(input fdc_in_t w, input bit known, input fdc_out_t want);
        fdc_out_t predicted;
        if ($urandom_range(99) < tx_idle_pct) begin
            bus_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(posedge clk);
        end
        bus_valid <= 1'b1;
        bus_item  <= w;
        @(posedge clk);
        while (!bus_ready)
            @(posedge clk);
        predicted = bus_access_result(w);
        result_q.push_back(known ? want : predicted);
        sent_words++;
    endtask

    task automatic issue(input fdc_in_t w);
        // A FIFO read here would return a byte never written since reset;
        // ask for the status byte instead.
        if (w.action == ACT_READ && w.port_offset == PORT_FIFO && cmd_ptr < FIFO_DEPTH &&
            !cmd_filled[cmd_ptr[FIFO_IDX_W-1:0]])
            w.port_offset = PORT_MSR;
        send_word(w, 1'b0, '0);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic run_command();
        logic [3:0] op;
        logic [7:0] head_byte;
        int         n;
        case ($urandom_range(5))
            0:       op = OP_SPECIFY;
            1:       op = OP_READ_DATA;
            2:       op = OP_RECAL;
            3:       op = OP_SENSE_INT;
            4:       op = OP_READ_ID;
            default: op = OP_SEEK;
        endcase
        n = bytes_for(op);
        head_byte      = 8'($urandom_range(255));
        head_byte[3:0] = op;
        if (op == OP_READ_DATA)
            head_byte[MT_BIT] = ($urandom_range(9) != 0);
        issue(make_word(ACT_WRITE, PORT_FIFO, head_byte));
        for (int k = 1; k < n; k++)
            issue(make_word(ACT_WRITE, PORT_FIFO, pick_byte()));
        if ($urandom_range(3) == 0)
            issue(make_word(ACT_READ, PORT_MSR, 8'($urandom_range(255))));
        // Read the result phase back while the status byte says data is waiting.
        for (int k = 0; k < 12 && (status_reg & MSR_DIO) != 0; k++) begin
            if ($urandom_range(19) == 0)
                break;
            issue(make_word(ACT_READ, PORT_FIFO, 8'($urandom_range(255))));
        end
    endtask

    task automatic run_noise();
        logic [7:0] head_byte;
        int         n;
        int         m;
        case ($urandom_range(4))
            0, 1: issue(make_word(1'($urandom_range(1)), 3'($urandom_range(7)),
                                  8'($urandom_range(255))));
            2:    issue(make_word(ACT_WRITE, PORT_DOR, 8'($urandom_range(255))));
            default: begin
                // A command cut short, one with an opcode the block does not know, or a whole one-byte command.
                head_byte = 8'($urandom_range(255));
                n = bytes_for(head_byte[3:0]);
                m = (n > 1) ? $urandom_range(n - 1, 1) : 1;
                issue(make_word(ACT_WRITE, PORT_FIFO, head_byte));
                for (int k = 1; k < m; k++)
                    issue(make_word(ACT_WRITE, PORT_FIFO, pick_byte()));
            end
        endcase
    endtask

    task automatic flag_field(input string name, input int unsigned want,
                              input int unsigned got);
        fail_count++;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    endtask

    initial begin
        forever begin
            @(posedge clk);
            if (hold_served != hold_asked) begin
                hold_served = hold_asked;
                res_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            res_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk) begin
        fdc_out_t want;
        if (rst_n && res_valid && res_ready) begin
            if (result_q.size() == 0) begin
                fail_count++;
                $display("%0t: expected no result word, got %0h", $time, res_item);
            end else begin
                want = result_q.pop_front();
                if (res_item.read_data !== want.read_data)
                    flag_field("read_data", want.read_data, res_item.read_data);
                if (res_item.irq_level !== want.irq_level)
                    flag_field("irq_level", want.irq_level, res_item.irq_level);
                if (res_item.irq_pulse !== want.irq_pulse)
                    flag_field("irq_pulse", want.irq_pulse, res_item.irq_pulse);
                if (res_item.dma_request !== want.dma_request)
                    flag_field("dma_request", want.dma_request, res_item.dma_request);
                if (res_item.dma_lba !== want.dma_lba)
                    flag_field("dma_lba", want.dma_lba, res_item.dma_lba);
                if (res_item.dma_count !== want.dma_count)
                    flag_field("dma_count", want.dma_count, res_item.dma_count);
                if (res_item.error_code !== want.error_code)
                    flag_field("error_code", want.error_code, res_item.error_code);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (bus_valid && bus_ready) || (res_valid && res_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int goal;
        model_reset();

        add_row(ACT_READ,  PORT_MSR,      8'h00, 8'h00, 1, want_of(MSR_RDY, 0, 0, ERR_NONE));
        add_row(ACT_READ,  PORT_SPARE_LO, 8'h00, 8'hFF, 1, want_of(8'h00, 0, 0, ERR_PORT));
        add_row(ACT_WRITE, PORT_SPARE_HI, 8'hFF, 8'h00, 1, want_of(8'h00, 0, 0, ERR_PORT));
        add_row(ACT_WRITE, PORT_CCR,      8'hFF, 8'hFF, 1, want_of(8'h00, 0, 0, ERR_NONE));
        add_row(ACT_WRITE, PORT_FIFO,     8'hF0, 8'h00, 1, want_of(8'h00, 0, 0, ERR_CMD));
        add_row(ACT_WRITE, PORT_FIFO, {4'hF, OP_SPECIFY},   8'h00, 0, '0);
        add_row(ACT_WRITE, PORT_FIFO,     8'hFF, 8'hFF, 0, '0);
        add_row(ACT_WRITE, PORT_FIFO, {4'h0, OP_SENSE_INT}, 8'h00, 0, '0);
        add_row(ACT_READ,  PORT_FIFO,     8'h00, 8'h00, 0, '0);
        add_row(ACT_READ,  PORT_FIFO,     8'hFF, 8'hFF, 0, '0);
        add_row(ACT_WRITE, PORT_FIFO, {4'h0, OP_SEEK},      8'h00, 0, '0);
        add_row(ACT_WRITE, PORT_FIFO,     8'hFF, 8'h00, 0, '0);
        add_row(ACT_WRITE, PORT_FIFO,     8'hFF, 8'hFF, 0, '0);
        add_row(ACT_WRITE, PORT_FIFO, {4'h4, OP_READ_ID},   8'h00, 0, '0);
        add_row(ACT_WRITE, PORT_FIFO,     8'h00, 8'h00, 0, '0);
        add_row(ACT_WRITE, PORT_FIFO, {4'h0, OP_RECAL},     8'hFF, 0, '0);
        add_row(ACT_WRITE, PORT_FIFO,     8'h00, 8'h00, 0, '0);
        add_row(ACT_WRITE, PORT_DOR,      8'hFF, 8'h00, 1, want_of(8'h00, 1, 1, ERR_NONE));
        // Read-data with the multi-track bit clear is aborted on its last byte.
        add_row(ACT_WRITE, PORT_FIFO, {4'h4, OP_READ_DATA}, 8'h00, 0, '0);
        add_row(ACT_WRITE, PORT_FIFO,     8'h00, 8'h00, 0, '0);
        add_row(ACT_WRITE, PORT_FIFO,     8'hFF, 8'h00, 0, '0);
        add_row(ACT_WRITE, PORT_FIFO,     8'hFF, 8'h00, 0, '0);
        add_row(ACT_WRITE, PORT_FIFO,     8'h00, 8'h00, 0, '0);
        add_row(ACT_WRITE, PORT_FIFO,     8'h02, 8'h00, 0, '0);
        add_row(ACT_WRITE, PORT_FIFO,     8'hFF, 8'h00, 0, '0);
        add_row(ACT_WRITE, PORT_FIFO,     8'h1B, 8'h00, 0, '0);
        add_row(ACT_WRITE, PORT_FIFO,     8'hFF, 8'hFF, 0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
            send_word(plan[k].word, plan[k].known, plan[k].want);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    // Long receiver hold-off while words keep coming, to fill the block.
                    hold_asked++;
                end
                1: begin
                    tx_idle_pct  = 58;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 58;
                end
                default: begin
                    tx_idle_pct  = 23;
                    rx_stall_pct = 23;
                end
            endcase
            goal = sent_words + PHASE_WORDS;
            while (sent_words < goal) begin
                if ($urandom_range(99) < 75)
                    run_command();
                else
                    run_noise();
            end
        end
        bus_valid <= 1'b0;

        while (result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
